@@ rtl/bvdc_pkg.sv @@
// shared constants and types for the battery voltage duty compensator
package bvdc_pkg;

  // default scaling of the compensator
  localparam int MAX_DUTY_DEF      = 1000;
  localparam int AVERAGE_SCALE_DEF = 1024;

  // fixed arithmetic constants
  localparam int PERCENT_LIMIT = 100;
  localparam int EMA_SHIFT     = 7;    // blend weight 1/128, keep 127/128

  // field widths
  localparam int CMD_W    = 3;
  localparam int MV_W     = 16;
  localparam int VOLT_W   = 17;
  localparam int DUTY_W   = 32;
  localparam int AVG_W    = 26;
  localparam int RESULT_W = 17;

  // divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int DIV_W  = 32;
  localparam int DVSR_W = 16;

  // stream beat widths, padded to whole bytes
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEED     = 3'd0,
    CMD_SAMPLE   = 3'd1,
    CMD_V2DUTY   = 3'd2,
    CMD_DUTY2V   = 3'd3,
    CMD_PCT2V    = 3'd4,
    CMD_RSVD5    = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_t;

endpackage

@@ rtl/battery_voltage_duty_compensator.sv @@
// top level: battery voltage average and duty/voltage conversions on a shared divider
// commands 0 to 4 pass through a multiply step, a load step, 32 radix-2 divide steps and an
// output step, in that order;
// unused command codes and a duty request on a zero average skip the divider
// one input beat is worked on at a time: the next beat is taken only after the result has gone
// to the output register, which may wait on m_tready; s_tready is low while an item is at work
// reset: rst (synchronous, active high) clears the average and the output valid
module battery_voltage_duty_compensator
  import bvdc_pkg::*;
#(
  parameter int MAX_DUTY      = MAX_DUTY_DEF,       // 1 .. 65535
  parameter int AVERAGE_SCALE = AVERAGE_SCALE_DEF   // 1 .. 1024
) (
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // command[2:0], sample_mv[18:3], target_voltage_mv[35:19], duty_value[67:36], zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // result_value[16:0], average_mv[32:17], zero_average_flag[33], zero pad
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [MV_W-1:0]   MAX_DUTY_V = MV_W'(MAX_DUTY);
  localparam logic [MV_W-1:0]   SCALE_V    = MV_W'(AVERAGE_SCALE);
  localparam logic [DIV_W-1:0]  MAX_DUTY_Q = DIV_W'(MAX_DUTY);
  localparam logic [DUTY_W-1:0] MAX_DUTY_D = DUTY_W'(MAX_DUTY);
  localparam logic [DUTY_W-1:0] PCT_LIM_D  = DUTY_W'(PERCENT_LIMIT);
  localparam logic [6:0]        PCT_LIM_S  = 7'(PERCENT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an input beat
    ST_MUL,    // shared multiplier forms the product
    ST_LOAD,   // average update, divider operands loaded
    ST_DIV,    // restoring divider, one quotient bit per cycle
    ST_FIN     // sign, clamp and hand to the output register
  } state_t;

  state_t               state;

  // captured input beat
  cmd_t                 cmd;
  logic [MV_W-1:0]      sample;
  logic [VOLT_W-1:0]    volt;
  logic [DUTY_W-1:0]    duty;

  // persistent state: scaled average and its millivolt quotient
  logic [AVG_W-1:0]     avg;
  logic [MV_W-1:0]      avg_mv;

  // datapath registers
  logic [VOLT_W+MV_W-1:0] product;
  logic [DIV_W-1:0]     quo;
  logic [DVSR_W-1:0]    rem;
  logic [DVSR_W-1:0]    divisor;
  logic [CNT_W-1:0]     cnt;
  logic                 zero_flag;

  // output register
  logic [RESULT_W-1:0]  out_result;
  logic [MV_W-1:0]      out_avg;
  logic                 out_flag;

  // combinational
  logic [VOLT_W-1:0]    vmag;
  logic [DUTY_W-1:0]    dmag;
  logic [MV_W-1:0]      duty_clamp;
  logic [6:0]           pct_clamp;
  logic [VOLT_W-1:0]    mul_a;
  logic [MV_W-1:0]      mul_b;
  logic [AVG_W+8-1:0]   ema_acc;
  logic [AVG_W-1:0]     avg_blend;
  logic [AVG_W-1:0]     avg_new;
  logic [DVSR_W:0]      shifted;
  logic [DVSR_W+1:0]    diff;
  logic                 neg;
  logic [MV_W-1:0]      mag;
  logic [RESULT_W-1:0]  result_signed;

  assign s_tready = (state == ST_IDLE);

  // magnitudes of the signed inputs; the most negative codes still fit unsigned
  assign vmag = volt[VOLT_W-1] ? (~volt + 1'b1) : volt;
  assign dmag = duty[DUTY_W-1] ? (~duty + 1'b1) : duty;

  // symmetric clamps applied on the magnitude
  assign duty_clamp = (dmag > MAX_DUTY_D) ? MAX_DUTY_V : dmag[MV_W-1:0];
  assign pct_clamp  = (dmag > PCT_LIM_D)  ? PCT_LIM_S  : dmag[6:0];

  // one multiplier shared by all commands
  always_comb begin
    unique case (cmd)
      CMD_SEED, CMD_SAMPLE: begin
        mul_a = VOLT_W'(sample);
        mul_b = SCALE_V;
      end
      CMD_V2DUTY: begin
        mul_a = vmag;
        mul_b = MAX_DUTY_V;
      end
      CMD_DUTY2V: begin
        mul_a = VOLT_W'(duty_clamp);
        mul_b = avg_mv;
      end
      CMD_PCT2V: begin
        mul_a = VOLT_W'(pct_clamp);
        mul_b = avg_mv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // avg*127 + sample*scale, then divide by 128
  assign ema_acc   = ({1'b0, avg, 7'b0} - {8'b0, avg}) + (AVG_W+8)'(product);
  assign avg_blend = ema_acc[AVG_W+EMA_SHIFT-1:EMA_SHIFT];
  assign avg_new   = (cmd == CMD_SEED) ? product[AVG_W-1:0] : avg_blend;

  // restoring divide step
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, divisor};

  // sign of the signed result and the clamped magnitude
  always_comb begin
    neg = 1'b0;
    mag = quo[MV_W-1:0];
    unique case (cmd)
      CMD_V2DUTY: begin
        neg = volt[VOLT_W-1];
        mag = (quo > MAX_DUTY_Q) ? MAX_DUTY_V : quo[MV_W-1:0];
      end
      CMD_DUTY2V, CMD_PCT2V: begin
        neg = duty[DUTY_W-1];
      end
      default: begin
        mag = '0;
      end
    endcase
  end

  assign result_signed = neg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      avg      <= '0;
      avg_mv   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output register drains independently of the sequencer; a new result
      // handed over in ST_FIN sets it instead
      if (m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd    <= cmd_t'(s_tdata[2:0]);
            sample <= s_tdata[18:3];
            volt   <= s_tdata[35:19];
            duty   <= s_tdata[67:36];
            state  <= ST_MUL;
          end
        end

        ST_MUL: begin
          product <= mul_a * mul_b;
          state   <= ST_LOAD;
        end

        ST_LOAD: begin
          rem       <= '0;
          cnt       <= CNT_W'(DIV_W - 1);
          zero_flag <= 1'b0;
          unique case (cmd)
            CMD_SEED, CMD_SAMPLE: begin
              // update the scaled average here; its millivolt quotient follows from the divide
              avg     <= avg_new;
              quo     <= DIV_W'(avg_new);
              divisor <= SCALE_V;
              state   <= ST_DIV;
            end
            CMD_V2DUTY: begin
              if (avg_mv == '0) begin
                // no average yet: saturate by the sign of the voltage
                zero_flag <= 1'b1;
                quo       <= (vmag != '0) ? MAX_DUTY_Q : '0;
                state     <= ST_FIN;
              end else begin
                quo     <= product[DIV_W-1:0];
                divisor <= avg_mv;
                state   <= ST_DIV;
              end
            end
            CMD_DUTY2V: begin
              quo     <= product[DIV_W-1:0];
              divisor <= MAX_DUTY_V;
              state   <= ST_DIV;
            end
            CMD_PCT2V: begin
              quo     <= product[DIV_W-1:0];
              divisor <= DVSR_W'(PERCENT_LIMIT);
              state   <= ST_DIV;
            end
            default: begin
              quo   <= '0;
              state <= ST_FIN;
            end
          endcase
        end

        ST_DIV: begin
          if (!diff[DVSR_W+1]) begin
            rem <= diff[DVSR_W-1:0];
            quo <= {quo[DIV_W-2:0], 1'b1};
          end else begin
            rem <= shifted[DVSR_W-1:0];
            quo <= {quo[DIV_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            if (cmd == CMD_SEED || cmd == CMD_SAMPLE) begin
              avg_mv  <= quo[MV_W-1:0];
              out_avg <= quo[MV_W-1:0];
            end else begin
              out_avg <= avg_mv;
            end
            out_result <= result_signed;
            out_flag   <= zero_flag;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(M_DATA_W - RESULT_W - MV_W - 1){1'b0}}, out_flag, out_avg, out_result};

  // an accepted beat keeps the input side closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again right after a beat");

  // the zero-average flag only comes with a zero average
  a_flag_avg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[32:17] == '0)
    else $error("zero average flag with nonzero average");

  // a saturated duty is +-MAX_DUTY or zero
  a_flag_saturates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |->
      (m_tdata[16:0] == RESULT_W'(MAX_DUTY)) || (m_tdata[16:0] == RESULT_W'(-MAX_DUTY))
      || (m_tdata[16:0] == '0))
    else $error("zero average result not saturated");

endmodule
